// ----- design/dls_pkg.sv -----
// Shared types, token kinds, scanner modes and character tables for the Datalog lexer.
`default_nettype none

package dls_pkg;

    // Field widths of one token word
    typedef logic [15:0] t_line;
    typedef logic [19:0] t_start;
    typedef logic [20:0] t_length;

    // Token kinds as they appear on the output
    typedef enum logic [4:0] {
        K_COMMA     = 5'd0,
        K_PERIOD    = 5'd1,
        K_QMARK     = 5'd2,
        K_LPAREN    = 5'd3,
        K_RPAREN    = 5'd4,
        K_COLON     = 5'd5,
        K_COLONDASH = 5'd6,
        K_MUL       = 5'd7,
        K_ADD       = 5'd8,
        K_SCHEMES   = 5'd9,
        K_FACTS     = 5'd10,
        K_RULES     = 5'd11,
        K_QUERIES   = 5'd12,
        K_ID        = 5'd13,
        K_STRING    = 5'd14,
        K_COMMENT   = 5'd15,
        K_BLOCKCMT  = 5'd16,
        K_UNDEF     = 5'd17,
        K_EOF       = 5'd18
    } t_kind;

    // Scanner modes
    typedef enum logic [3:0] {
        M_IDLE     = 4'd0,
        M_IDENT    = 4'd1,
        M_COLON    = 4'd2,
        M_HASH     = 4'd3,
        M_LINECMT  = 4'd4,
        M_BLOCK    = 4'd5,
        M_BLOCKBAR = 4'd6,
        M_STRING   = 4'd7,
        M_STRQUOTE = 4'd8
    } t_mode;

    // One token word
    typedef struct packed {
        t_kind   kind;
        t_line   line;
        t_start  start;
        t_length length;
        logic    last;
    } t_tok;

    // Tokens produced by one step of the scanner
    typedef struct packed {
        logic [1:0] cnt;
        t_tok       tok0;
        t_tok       tok1;
    } t_emit;

    // Characters with a role of their own
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_BAR   = 8'h7C;

    // Keywords, left aligned, zero padded to seven characters
    localparam int unsigned NUM_KW = 4;
    localparam logic [55:0] KW_TEXT [NUM_KW] = '{
        "Schemes", {"Facts", 16'h0000}, {"Rules", 16'h0000}, "Queries"
    };
    localparam int unsigned KW_LEN [NUM_KW] = '{7, 5, 5, 7};
    localparam t_kind KW_KIND [NUM_KW] = '{K_SCHEMES, K_FACTS, K_RULES, K_QUERIES};

    // Character i of keyword k
    function automatic logic [7:0] kw_char(input int unsigned k, input logic [2:0] i);
        logic [55:0] s;
        s = KW_TEXT[k];
        case (i)
            3'd0:    return s[55:48];
            3'd1:    return s[47:40];
            3'd2:    return s[39:32];
            3'd3:    return s[31:24];
            3'd4:    return s[23:16];
            3'd5:    return s[15:8];
            3'd6:    return s[7:0];
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c inside {["0":"9"], ["A":"Z"], ["a":"z"]});
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c inside {8'h20, [8'h09:8'h0D]});
    endfunction

    // Single-character tokens; anything else is undefined
    function automatic t_kind punct_kind(input logic [7:0] c);
        case (c)
            ",":     return K_COMMA;
            ".":     return K_PERIOD;
            "?":     return K_QMARK;
            "(":     return K_LPAREN;
            ")":     return K_RPAREN;
            "*":     return K_MUL;
            "+":     return K_ADD;
            default: return K_UNDEF;
        endcase
    endfunction

endpackage

`default_nettype wire

// ----- design/dls_if.sv -----
// Valid/ready channel interfaces for character words and token words.
`default_nettype none

interface dls_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_input;

    modport source (output valid, output char_code, output end_of_input, input ready);
    modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

interface dls_tok_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [15:0] token_line;
    logic [19:0] token_start;
    logic [20:0] token_length;
    logic        last_in_run;

    modport source (output valid, output token_kind, output token_line, output token_start,
                    output token_length, output last_in_run, input ready);
    modport sink   (input valid, input token_kind, input token_line, input token_start,
                    input token_length, input last_in_run, output ready);
endinterface

`default_nettype wire

// ----- design/dls_scan.sv -----
// Scanner core: mode and counter registers, one character or end mark per step.
`default_nettype none

module dls_scan
    import dls_pkg::*;
#(
    parameter longint unsigned MAX_INPUT_BYTES = 64'd1048576,
    parameter longint unsigned MAX_LINES       = 64'd65535
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_fire,
    input  wire  [7:0] i_char,
    input  wire        i_eoi,
    output t_emit      o_emit
);

    localparam int OFS_W  = $clog2(MAX_INPUT_BYTES);
    localparam int LEN_W  = $clog2(MAX_INPUT_BYTES + 64'd1);
    localparam int LINE_W = $clog2(MAX_LINES + 64'd1);

    localparam logic [OFS_W-1:0]  OFS_MAX  = OFS_W'(MAX_INPUT_BYTES - 64'd1);
    localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_INPUT_BYTES);
    localparam logic [LINE_W-1:0] LINE_MAX = LINE_W'(MAX_LINES);

    t_mode             r_mode, n_mode;
    logic [3:0]        r_kw, n_kw;
    logic [LINE_W-1:0] r_line, n_line;
    logic [OFS_W-1:0]  r_ofs, n_ofs;
    logic [OFS_W-1:0]  r_so, n_so;
    logic [LINE_W-1:0] r_sl, n_sl;
    logic [LEN_W-1:0]  r_pl, n_pl;

    t_tok       v_tok [2];
    logic [1:0] v_cnt;

    function automatic t_tok mk_tok(input t_kind kind, input logic [LINE_W-1:0] line,
                                    input logic [OFS_W-1:0] start,
                                    input logic [LEN_W-1:0] len);
        t_tok t;
        t        = '0;
        t.kind   = kind;
        t.line   = t_line'(line);
        t.start  = t_start'(start);
        t.length = t_length'(len);
        return t;
    endfunction

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_kw   <= 4'hF;
            r_line <= LINE_W'(1);
            r_ofs  <= '0;
            r_so   <= '0;
            r_sl   <= LINE_W'(1);
            r_pl   <= '0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_kw   <= n_kw;
            r_line <= n_line;
            r_ofs  <= n_ofs;
            r_so   <= n_so;
            r_sl   <= n_sl;
            r_pl   <= n_pl;
        end
    end

    // Next state and tokens for one step
    always_comb begin
        logic       fresh;
        t_kind      kind;
        n_mode   = r_mode;
        n_kw     = r_kw;
        n_line   = r_line;
        n_ofs    = r_ofs;
        n_so     = r_so;
        n_sl     = r_sl;
        n_pl     = r_pl;
        v_tok[0] = '0;
        v_tok[1] = '0;
        v_cnt    = 2'd0;
        fresh    = 1'b0;
        kind     = K_ID;

        if (i_eoi) begin
            // flush the pending token, then EOF
            case (r_mode)
                M_IDENT: begin
                    for (int unsigned k = 0; k < NUM_KW; k++) begin
                        if (r_kw[k] && r_pl == LEN_W'(KW_LEN[k])) kind = KW_KIND[k];
                    end
                    v_tok[v_cnt[0]] = mk_tok(kind, n_line, n_so, n_pl);
                    v_cnt = v_cnt + 2'd1;
                end
                M_COLON: begin
                    v_tok[v_cnt[0]] = mk_tok(K_COLON, n_line, n_so, n_pl);
                    v_cnt = v_cnt + 2'd1;
                end
                M_HASH, M_LINECMT: begin
                    v_tok[v_cnt[0]] = mk_tok(K_COMMENT, n_line, n_so, n_pl);
                    v_cnt = v_cnt + 2'd1;
                end
                M_BLOCK, M_BLOCKBAR, M_STRING: begin
                    v_tok[v_cnt[0]] = mk_tok(K_UNDEF, n_sl, n_so, n_pl);
                    v_cnt = v_cnt + 2'd1;
                end
                M_STRQUOTE: begin
                    v_tok[v_cnt[0]] = mk_tok(K_STRING, n_sl, n_so, n_pl);
                    v_cnt = v_cnt + 2'd1;
                end
                default: begin
                end
            endcase
            n_mode = M_IDLE;
            n_kw   = 4'hF;
            v_tok[v_cnt[0]] = mk_tok(K_EOF, n_line, n_ofs, '0);
            v_cnt = v_cnt + 2'd1;
        end else begin
            case (r_mode)
                M_IDENT: begin
                    if (is_alnum(i_char)) begin
                        for (int unsigned k = 0; k < NUM_KW; k++) begin
                            if (!(r_pl < LEN_W'(KW_LEN[k])) || kw_char(k, r_pl[2:0]) != i_char)
                                n_kw[k] = 1'b0;
                        end
                        if (n_pl < LEN_MAX) n_pl = n_pl + 1'b1;
                    end else begin
                        for (int unsigned k = 0; k < NUM_KW; k++) begin
                            if (r_kw[k] && r_pl == LEN_W'(KW_LEN[k])) kind = KW_KIND[k];
                        end
                        v_tok[v_cnt[0]] = mk_tok(kind, n_line, n_so, n_pl);
                        v_cnt  = v_cnt + 2'd1;
                        n_kw   = 4'hF;
                        n_mode = M_IDLE;
                        fresh  = 1'b1;
                    end
                end
                M_COLON: begin
                    n_mode = M_IDLE;
                    if (i_char == CH_DASH) begin
                        if (n_pl < LEN_MAX) n_pl = n_pl + 1'b1;
                        v_tok[v_cnt[0]] = mk_tok(K_COLONDASH, n_line, n_so, n_pl);
                        v_cnt = v_cnt + 2'd1;
                    end else begin
                        v_tok[v_cnt[0]] = mk_tok(K_COLON, n_line, n_so, n_pl);
                        v_cnt = v_cnt + 2'd1;
                        fresh = 1'b1;
                    end
                end
                M_HASH: begin
                    if (i_char == CH_BAR) begin
                        if (n_pl < LEN_MAX) n_pl = n_pl + 1'b1;
                        n_mode = M_BLOCK;
                    end else if (i_char == CH_LF) begin
                        v_tok[v_cnt[0]] = mk_tok(K_COMMENT, n_line, n_so, n_pl);
                        v_cnt = v_cnt + 2'd1;
                        if (n_line < LINE_MAX) n_line = n_line + 1'b1;
                        n_mode = M_IDLE;
                    end else begin
                        if (n_pl < LEN_MAX) n_pl = n_pl + 1'b1;
                        n_mode = M_LINECMT;
                    end
                end
                M_LINECMT: begin
                    if (i_char == CH_LF) begin
                        v_tok[v_cnt[0]] = mk_tok(K_COMMENT, n_line, n_so, n_pl);
                        v_cnt = v_cnt + 2'd1;
                        if (n_line < LINE_MAX) n_line = n_line + 1'b1;
                        n_mode = M_IDLE;
                    end else begin
                        if (n_pl < LEN_MAX) n_pl = n_pl + 1'b1;
                    end
                end
                M_BLOCK: begin
                    if (n_pl < LEN_MAX) n_pl = n_pl + 1'b1;
                    if (i_char == CH_BAR) begin
                        n_mode = M_BLOCKBAR;
                    end else if (i_char == CH_LF) begin
                        if (n_line < LINE_MAX) n_line = n_line + 1'b1;
                    end
                end
                M_BLOCKBAR: begin
                    if (n_pl < LEN_MAX) n_pl = n_pl + 1'b1;
                    if (i_char == CH_HASH) begin
                        v_tok[v_cnt[0]] = mk_tok(K_BLOCKCMT, n_sl, n_so, n_pl);
                        v_cnt  = v_cnt + 2'd1;
                        n_mode = M_IDLE;
                    end else if (i_char != CH_BAR) begin
                        if (i_char == CH_LF && n_line < LINE_MAX) n_line = n_line + 1'b1;
                        n_mode = M_BLOCK;
                    end
                end
                M_STRING: begin
                    if (n_pl < LEN_MAX) n_pl = n_pl + 1'b1;
                    if (i_char == CH_QUOTE) begin
                        n_mode = M_STRQUOTE;
                    end else if (i_char == CH_LF) begin
                        if (n_line < LINE_MAX) n_line = n_line + 1'b1;
                    end
                end
                M_STRQUOTE: begin
                    if (i_char == CH_QUOTE) begin
                        // doubled quote stays in the string
                        if (n_pl < LEN_MAX) n_pl = n_pl + 1'b1;
                        n_mode = M_STRING;
                    end else begin
                        v_tok[v_cnt[0]] = mk_tok(K_STRING, n_sl, n_so, n_pl);
                        v_cnt  = v_cnt + 2'd1;
                        n_mode = M_IDLE;
                        fresh  = 1'b1;
                    end
                end
                default: begin
                    n_mode = M_IDLE;
                    fresh  = 1'b1;
                end
            endcase

            // character starts a new token from idle
            if (fresh) begin
                n_so = n_ofs;
                n_sl = n_line;
                n_pl = LEN_W'(1);
                n_kw = 4'hF;
                if (is_alnum(i_char)) begin
                    for (int unsigned k = 0; k < NUM_KW; k++) begin
                        if (kw_char(k, 3'd0) != i_char) n_kw[k] = 1'b0;
                    end
                    n_mode = M_IDENT;
                end else if (is_space(i_char)) begin
                    n_pl = '0;
                    if (i_char == CH_LF && n_line < LINE_MAX) n_line = n_line + 1'b1;
                end else if (i_char == CH_COLON) begin
                    n_mode = M_COLON;
                end else if (i_char == CH_QUOTE) begin
                    n_mode = M_STRING;
                end else if (i_char == CH_HASH) begin
                    n_mode = M_HASH;
                end else begin
                    v_tok[v_cnt[0]] = mk_tok(punct_kind(i_char), n_line, n_so, LEN_W'(1));
                    v_cnt = v_cnt + 2'd1;
                end
            end

            if (n_ofs < OFS_MAX) n_ofs = n_ofs + 1'b1;
        end

        // mark the last token of the step
        if (v_cnt == 2'd1) v_tok[0].last = 1'b1;
        if (v_cnt == 2'd2) v_tok[1].last = 1'b1;
    end

    assign o_emit.cnt  = i_fire ? v_cnt : 2'd0;
    assign o_emit.tok0 = v_tok[0];
    assign o_emit.tok1 = v_tok[1];

endmodule

`default_nettype wire

// ----- design/dls_tok_fifo.sv -----
// Four-word token queue that takes up to two words a cycle and gives one.
`default_nettype none

module dls_tok_fifo
    import dls_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  t_emit  i_emit,
    input  wire    i_pop,
    output logic   o_room,
    output logic   o_valid,
    output t_tok   o_head
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_tok             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] wptr1;

    assign wptr1 = r_wptr + 1'b1;

    // Storage, no reset on payload
    always_ff @(posedge i_clk) begin
        if (i_emit.cnt != 2'd0) r_mem[r_wptr] <= i_emit.tok0;
        if (i_emit.cnt == 2'd2) r_mem[wptr1] <= i_emit.tok1;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + PTR_W'(i_emit.cnt);
            r_rptr  <= r_rptr + PTR_W'(i_pop);
            r_count <= r_count + CNT_W'(i_emit.cnt) - CNT_W'(i_pop);
        end
    end

    // Room for a full step's worth of tokens
    assign o_room  = (r_count <= CNT_W'(DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];

endmodule

`default_nettype wire

// ----- design/datalog_lexer_stream.sv -----
// A character word is taken into the input register and scanned once the token queue has room;
// the scan writes its token words into the queue, whose head word is on the output.
// Throughput: one character word per cycle; the four-word token queue holds input back
// while it has fewer than two free slots, so output bandwidth of one token word a cycle sets it.
// Reset: synchronous, active low; clears the scanner mode, line and offset counters and
// empties the token queue.
`default_nettype none

module datalog_lexer_stream
    import dls_pkg::*;
#(
    parameter longint unsigned MAX_INPUT_BYTES = 64'd1048576,
    parameter longint unsigned MAX_LINES       = 64'd65535
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    dls_in_if.sink           i_in,
    dls_tok_if.source        o_tok
);

    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_eoi;
    logic       room;
    logic       fire;
    logic       head_valid;
    t_tok       head;
    t_emit      emit;

    assign fire       = r_in_valid && room;
    assign i_in.ready = !r_in_valid || fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_char <= i_in.char_code;
            r_eoi  <= i_in.end_of_input;
        end
    end

    dls_scan #(
        .MAX_INPUT_BYTES (MAX_INPUT_BYTES),
        .MAX_LINES       (MAX_LINES)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_char  (r_char),
        .i_eoi   (r_eoi),
        .o_emit  (emit)
    );

    dls_tok_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .i_pop   (head_valid && o_tok.ready),
        .o_room  (room),
        .o_valid (head_valid),
        .o_head  (head)
    );

    // Token word out
    assign o_tok.valid        = head_valid;
    assign o_tok.token_kind   = head.kind;
    assign o_tok.token_line   = head.line;
    assign o_tok.token_start  = head.start;
    assign o_tok.token_length = head.length;
    assign o_tok.last_in_run  = head.last;

endmodule

`default_nettype wire

// ----- design/dls_checker.sv -----
// Port-level checks on the token output of the lexer, bound to the top level.
`default_nettype none

module dls_checker
    import dls_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_tok_valid,
    input wire        i_tok_ready,
    input wire [4:0]  i_tok_kind,
    input wire [15:0] i_tok_line,
    input wire [20:0] i_tok_length,
    input wire        i_tok_last
);

    // stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tok_valid && !i_tok_ready |=> i_tok_valid && $stable(i_tok_kind)
            && $stable(i_tok_length) && $stable(i_tok_last))
        else $error("token word changed while stalled");

    // the second token of a step is already queued with the first
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tok_valid && i_tok_ready && !i_tok_last |=> i_tok_valid)
        else $error("token run broken after a non-last word");

    // EOF closes its run and has no text
    a_eof_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tok_valid && i_tok_kind == K_EOF |-> i_tok_last && i_tok_length == 21'd0)
        else $error("EOF word malformed");

    // lines count from one
    a_line_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tok_valid |-> i_tok_line != 16'd0)
        else $error("token line is zero");

endmodule

bind datalog_lexer_stream dls_checker u_dls_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_tok_valid  (o_tok.valid),
    .i_tok_ready  (o_tok.ready),
    .i_tok_kind   (o_tok.token_kind),
    .i_tok_line   (o_tok.token_line),
    .i_tok_length (o_tok.token_length),
    .i_tok_last   (o_tok.last_in_run)
);

`default_nettype wire

// ----- tb/tb_datalog_lexer_stream.sv -----
// Testbench for datalog_lexer_stream: drives characters, predicts token words, checks them.
`timescale 1ns / 1ps

import dls_pkg::*;

// Token predictor and the list of token words still due from the block
class token_tracker;
    localparam int unsigned LINES_TOP = 65535;
    localparam int unsigned BYTES_TOP = 1048576;

    t_mode       mode;
    bit [3:0]    kw_alive;
    int unsigned line_no;
    int unsigned offset;
    int unsigned tok_start;
    int unsigned tok_line;
    int unsigned tok_len;
    string       kw_word[4];
    t_kind       kw_tag[4];
    t_tok        tokens_due[$];
    t_tok        step_toks[$];
    int unsigned failures;

    function new();
        kw_word  = '{"Schemes", "Facts", "Rules", "Queries"};
        kw_tag   = '{K_SCHEMES, K_FACTS, K_RULES, K_QUERIES};
        failures = 0;
        mode     = M_IDLE;
        kw_alive = 4'hF;
        line_no  = 1;
        offset   = 0;
        tok_start = 0;
        tok_line = 1;
        tok_len  = 0;
    endfunction

    function bit is_word_char(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function bit is_blank(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function t_kind single_kind(logic [7:0] c);
        case (c)
            ",":     return K_COMMA;
            ".":     return K_PERIOD;
            "?":     return K_QMARK;
            "(":     return K_LPAREN;
            ")":     return K_RPAREN;
            "*":     return K_MUL;
            "+":     return K_ADD;
            default: return K_UNDEF;
        endcase
    endfunction

    function void push(t_kind k, int unsigned ln, int unsigned st, int unsigned len);
        t_tok t;
        t.kind   = k;
        t.line   = ln[15:0];
        t.start  = st[19:0];
        t.length = len[20:0];
        t.last   = 1'b0;
        step_toks.insert(step_toks.size(), t);
    endfunction

    function void lengthen();
        if (tok_len < BYTES_TOP) tok_len++;
    endfunction

    function void next_line();
        if (line_no < LINES_TOP) line_no++;
    endfunction

    // Drop keywords that no longer match at the current position
    function void narrow(logic [7:0] c);
        for (int k = 0; k < 4; k++) begin
            if (tok_len >= kw_word[k].len() || kw_word[k][tok_len] != c) kw_alive[k] = 1'b0;
        end
    endfunction

    function void end_ident();
        t_kind kind;
        kind = K_ID;
        for (int k = 0; k < 4; k++) begin
            if (kw_alive[k] && tok_len == kw_word[k].len()) kind = kw_tag[k];
        end
        push(kind, line_no, tok_start, tok_len);
        kw_alive = 4'hF;
        mode     = M_IDLE;
    endfunction

    // Character seen with no token open
    function void begin_token(logic [7:0] c);
        tok_start = offset;
        tok_line  = line_no;
        tok_len   = 1;
        kw_alive  = 4'hF;
        if (is_word_char(c)) begin
            tok_len = 0;
            narrow(c);
            tok_len = 1;
            mode    = M_IDENT;
        end else if (is_blank(c)) begin
            tok_len = 0;
            if (c == 8'h0A) next_line();
        end else if (c == ":") begin
            mode = M_COLON;
        end else if (c == "'") begin
            mode = M_STRING;
        end else if (c == "#") begin
            mode = M_HASH;
        end else begin
            push(single_kind(c), line_no, tok_start, 1);
        end
    endfunction

    function void take_char(logic [7:0] c);
        bit fresh;
        fresh = 1'b0;
        case (mode)
            M_IDENT: begin
                if (is_word_char(c)) begin
                    narrow(c);
                    lengthen();
                end else begin
                    end_ident();
                    fresh = 1'b1;
                end
            end
            M_COLON: begin
                mode = M_IDLE;
                if (c == "-") begin
                    lengthen();
                    push(K_COLONDASH, line_no, tok_start, tok_len);
                end else begin
                    push(K_COLON, line_no, tok_start, tok_len);
                    fresh = 1'b1;
                end
            end
            M_HASH: begin
                if (c == "|") begin
                    lengthen();
                    mode = M_BLOCK;
                end else if (c == 8'h0A) begin
                    push(K_COMMENT, line_no, tok_start, tok_len);
                    next_line();
                    mode = M_IDLE;
                end else begin
                    lengthen();
                    mode = M_LINECMT;
                end
            end
            M_LINECMT: begin
                if (c == 8'h0A) begin
                    push(K_COMMENT, line_no, tok_start, tok_len);
                    next_line();
                    mode = M_IDLE;
                end else begin
                    lengthen();
                end
            end
            M_BLOCK: begin
                lengthen();
                if (c == "|") mode = M_BLOCKBAR;
                else if (c == 8'h0A) next_line();
            end
            M_BLOCKBAR: begin
                lengthen();
                if (c == "#") begin
                    push(K_BLOCKCMT, tok_line, tok_start, tok_len);
                    mode = M_IDLE;
                end else if (c != "|") begin
                    if (c == 8'h0A) next_line();
                    mode = M_BLOCK;
                end
            end
            M_STRING: begin
                lengthen();
                if (c == "'") mode = M_STRQUOTE;
                else if (c == 8'h0A) next_line();
            end
            M_STRQUOTE: begin
                // doubled quote stays inside the string
                if (c == "'") begin
                    lengthen();
                    mode = M_STRING;
                end else begin
                    push(K_STRING, tok_line, tok_start, tok_len);
                    mode  = M_IDLE;
                    fresh = 1'b1;
                end
            end
            default: begin
                mode  = M_IDLE;
                fresh = 1'b1;
            end
        endcase
        if (fresh) begin_token(c);
        if (offset < BYTES_TOP - 1) offset++;
    endfunction

    // End of input: flush whatever is open, then EOF
    function void take_end();
        case (mode)
            M_IDENT:                       end_ident();
            M_COLON:                       push(K_COLON, line_no, tok_start, tok_len);
            M_HASH, M_LINECMT:             push(K_COMMENT, line_no, tok_start, tok_len);
            M_BLOCK, M_BLOCKBAR, M_STRING: push(K_UNDEF, tok_line, tok_start, tok_len);
            M_STRQUOTE:                    push(K_STRING, tok_line, tok_start, tok_len);
            default: ;
        endcase
        mode     = M_IDLE;
        kw_alive = 4'hF;
        push(K_EOF, line_no, offset, 0);
    endfunction

    function void note_word(logic [7:0] c, logic eoi);
        step_toks.delete();
        if (eoi) take_end();
        else take_char(c);
        if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
        foreach (step_toks[i]) tokens_due.insert(tokens_due.size(), step_toks[i]);
    endfunction

    function bit same(string what, logic [20:0] want, logic [20:0] got);
        if (got === want) return 1'b1;
        $display("%0t: token %s expected %0d, got %0d", $time, what, want, got);
        return 1'b0;
    endfunction

    function void check_token(t_tok got);
        t_tok want;
        bit   ok;
        if (tokens_due.size() == 0) begin
            $display("%0t: unexpected token word, kind %0d line %0d start %0d length %0d",
                     $time, got.kind, got.line, got.start, got.length);
            failures++;
            return;
        end
        want = tokens_due.pop_front();
        ok = same("kind", want.kind, got.kind) & same("line", want.line, got.line)
           & same("start", want.start, got.start) & same("length", want.length, got.length)
           & same("last", want.last, got.last);
        if (!ok) failures++;
    endfunction
endclass

module tb_datalog_lexer_stream;

    localparam int unsigned STUCK_LIMIT = 2000;
    localparam int unsigned WORD_TARGET = 545;

    logic i_clk;
    logic i_rst_n;

    dls_in_if  in_ch ();
    dls_tok_if tok_ch ();

    datalog_lexer_stream u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_tok   (tok_ch)
    );

    token_tracker book;
    int unsigned  words_sent = 0;
    int unsigned  stuck = 0;
    bit           calm = 1'b0;
    string        puncts = ",.?()*+";
    logic [7:0]   blanks[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Token sink: random back-pressure, none during the calm stretch
    always @(negedge i_clk) begin
        if (!i_rst_n) tok_ch.ready <= 1'b0;
        else tok_ch.ready <= calm || ($urandom_range(0, 99) >= 34);
    end

    // Check every accepted token word
    always @(posedge i_clk) begin
        t_tok got;
        if (tok_ch.valid && tok_ch.ready) begin
            got.kind   = t_kind'(tok_ch.token_kind);
            got.line   = tok_ch.token_line;
            got.start  = tok_ch.token_start;
            got.length = tok_ch.token_length;
            got.last   = tok_ch.last_in_run;
            book.check_token(got);
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (tok_ch.valid && tok_ch.ready)) stuck <= 0;
        else stuck <= stuck + 1;
        if (stuck >= STUCK_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, stuck);
            $display("datalog_lexer_stream test failed");
            $finish;
        end
    end

    // Offer one word at the falling edge, hold it until it is taken
    task automatic send_word(input logic [7:0] c, input logic eoi);
        while (!calm && $urandom_range(0, 99) < 34) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.char_code    <= c;
        in_ch.end_of_input <= eoi;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        book.note_word(c, eoi);
        words_sent++;
        calm = (words_sent >= 250 && words_sent < 330);
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
    endtask

    function automatic logic [7:0] rand_alnum();
        int unsigned r;
        r = $urandom_range(0, 61);
        return (r < 10) ? 8'(48 + r) : (r < 36) ? 8'(55 + r) : 8'(61 + r);
    endfunction

    // One random lexeme, mostly well formed, sometimes cut short or broken
    task automatic send_fragment();
        int unsigned pick;
        int unsigned n;
        int unsigned flip;
        bit          extra;
        string       w;
        logic [7:0]  c;
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            // keyword: exact, truncated, extended or with one letter's case flipped
            w     = book.kw_word[$urandom_range(0, 3)];
            n     = w.len();
            flip  = n;
            extra = 1'b0;
            case ($urandom_range(0, 4))
                2: n = $urandom_range(1, n - 1);
                3: extra = 1'b1;
                4: flip = $urandom_range(0, n - 1);
                default: ;
            endcase
            for (int i = 0; i < n; i++) send_word((i == flip) ? (w[i] ^ 8'h20) : w[i], 1'b0);
            if (extra) send_word(rand_alnum(), 1'b0);
        end else if (pick < 28) begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) send_word(rand_alnum(), 1'b0);
        end else if (pick < 38) begin
            // quoted string with doubled quotes and line breaks
            send_word("'", 1'b0);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 9))
                    0, 1: send_text("''");
                    2: send_word(8'h0A, 1'b0);
                    default: begin
                        c = 8'($urandom_range(32, 126));
                        send_word((c == "'") ? "q" : c, 1'b0);
                    end
                endcase
            end
            if ($urandom_range(0, 9) != 0) send_word("'", 1'b0);
        end else if (pick < 45) begin
            send_word("#", 1'b0);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) send_word(8'($urandom_range(32, 126)), 1'b0);
            if ($urandom_range(0, 9) != 0) send_word(8'h0A, 1'b0);
        end else if (pick < 52) begin
            // block comment with stray bars, hashes and newlines
            send_text("#|");
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 5))
                    0: send_word("|", 1'b0);
                    1: send_word("#", 1'b0);
                    2: send_word(8'h0A, 1'b0);
                    default: send_word(8'($urandom_range(32, 126)), 1'b0);
                endcase
            end
            if ($urandom_range(0, 9) != 0) send_text("|#");
        end else if (pick < 64) begin
            send_word(puncts[$urandom_range(0, 6)], 1'b0);
        end else if (pick < 72) begin
            send_word(":", 1'b0);
            if ($urandom_range(0, 1)) send_word("-", 1'b0);
        end else if (pick < 87) begin
            send_word(blanks[$urandom_range(0, 5)], 1'b0);
        end else if (pick < 97) begin
            send_word(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            send_word(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    initial begin
        book                = new();
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.char_code     = 8'h00;
        in_ch.end_of_input  = 1'b0;
        tok_ch.ready        = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: keyword, colon-dash, colon lookahead, escaped string, block
        // comment over a line break, high byte, line comment, open block comment
        // and open string at end of input, repeated end of input
        send_text("Rules:-x:'a''b'#|\n|#");
        send_word(8'hFF, 1'b0);
        send_text("#c\n");
        send_word(8'h00, 1'b1);
        send_text("#|");
        send_word(8'hA5, 1'b1);
        send_text("'");
        send_word(8'h5A, 1'b1);
        send_word(8'h00, 1'b1);

        // Random lexemes, then a final flush
        while (words_sent < WORD_TARGET) send_fragment();
        send_word(8'($urandom_range(0, 255)), 1'b1);
        in_ch.valid <= 1'b0;

        while (book.tokens_due.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (book.tokens_due.size() != 0) begin
            $display("%0t: %0d token words never arrived", $time, book.tokens_due.size());
            book.failures++;
        end
        if (book.failures == 0) begin
            $display("datalog_lexer_stream test passed");
        end else begin
            $display("datalog_lexer_stream test failed");
        end
        $finish;
    end

endmodule
